### rtl/subtractive_lagged_rng_unit_assert.svh
// Assertion macros shared by the checker of the subtractive lagged generator.
`ifndef SUBTRACTIVE_LAGGED_RNG_UNIT_ASSERT_SVH
`define SUBTRACTIVE_LAGGED_RNG_UNIT_ASSERT_SVH

// Check a property on the clock, ignoring cycles held in reset.
`define SLRNG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on the clock, reset cycles included.
`define SLRNG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/slrng_pkg.sv
// Types, constants, microcode and arithmetic helpers of the subtractive lagged generator.
package slrng_pkg;

    localparam logic [29:0] MODULUS     = 30'd1000000000;
    localparam logic [27:0] SEED_BASE   = 28'd161803398;
    localparam logic [5:0]  STRIDE      = 6'd21;
    localparam logic [5:0]  WORDS       = 6'd55;
    localparam logic [5:0]  WARM_OFFSET = 6'd30;
    localparam logic [5:0]  FAR_START   = 6'd31;
    localparam logic [5:0]  FILL_STEPS  = 6'd54;
    localparam logic [1:0]  LAST_PASS   = 2'd3;

    typedef logic [2:0] t_step;

    localparam t_step STEP_IDLE    = 3'd0;
    localparam t_step STEP_DISP    = 3'd1;
    localparam t_step STEP_SEED    = 3'd2;
    localparam t_step STEP_FILL    = 3'd3;
    localparam t_step STEP_WARM_RD = 3'd4;
    localparam t_step STEP_WARM_WR = 3'd5;
    localparam t_step STEP_DRAW_RD = 3'd6;
    localparam t_step STEP_DRAW_WR = 3'd7;

    typedef enum logic [2:0] {
        C_NONE,
        C_NO_INPUT,
        C_DRAW_ONLY,
        C_FILL_MORE,
        C_WARM_MORE,
        C_OUT_BUSY
    } t_cond;

    // Datapath actions of one microcode step.
    typedef struct packed {
        logic accept;
        logic seed_load;
        logic fill;
        logic warm_rd;
        logic warm_wr;
        logic draw_rd;
        logic draw_wr;
    } t_ctl;

    typedef struct packed {
        t_ctl  ctl;
        t_cond cond;
        t_step target;
        logic  ret;
    } t_uword;

    // Status the datapath reports back for conditional jumps.
    typedef struct packed {
        logic in_valid;
        logic draw_only;
        logic fill_more;
        logic warm_more;
        logic out_busy;
    } t_flags;

    localparam t_ctl CTL_NONE = '0;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{ctl: CTL_NONE, cond: C_NONE, target: STEP_IDLE, ret: 1'b0};
        unique case (step)
            STEP_IDLE: begin
                w.ctl.accept = 1'b1;
                w.cond       = C_NO_INPUT;
                w.target     = STEP_IDLE;
            end
            STEP_DISP: begin
                w.cond   = C_DRAW_ONLY;
                w.target = STEP_DRAW_RD;
            end
            STEP_SEED: begin
                w.ctl.seed_load = 1'b1;
            end
            STEP_FILL: begin
                w.ctl.fill = 1'b1;
                w.cond     = C_FILL_MORE;
                w.target   = STEP_FILL;
            end
            STEP_WARM_RD: begin
                w.ctl.warm_rd = 1'b1;
            end
            STEP_WARM_WR: begin
                w.ctl.warm_wr = 1'b1;
                w.cond        = C_WARM_MORE;
                w.target      = STEP_WARM_RD;
            end
            STEP_DRAW_RD: begin
                w.ctl.draw_rd = 1'b1;
            end
            STEP_DRAW_WR: begin
                w.ctl.draw_wr = 1'b1;
                w.cond        = C_OUT_BUSY;
                w.target      = STEP_DRAW_WR;
                w.ret         = 1'b1;
            end
            default: begin
                w.ret = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic logic [29:0] mod_sub(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] t;
        if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
        end else begin
            t = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
        end
        return t[29:0];
    endfunction

    // Advance a table index, wrapping past the last word back to the first.
    function automatic logic [5:0] step_index(input logic [5:0] i);
        logic [5:0] n;
        if (i >= WORDS) begin
            n = 6'd1;
        end else begin
            n = i + 6'd1;
        end
        return n;
    endfunction

    function automatic logic [5:0] warm_other(input logic [5:0] i);
        logic [6:0] s;
        s = {1'b0, i} + {1'b0, WARM_OFFSET};
        if (s >= {1'b0, WORDS}) begin
            s = s - {1'b0, WORDS};
        end
        return s[5:0] + 6'd1;
    endfunction

    function automatic logic [5:0] next_slot(input logic [5:0] slot);
        logic [6:0] s;
        s = {1'b0, slot} + {1'b0, STRIDE};
        if (s >= {1'b0, WORDS}) begin
            s = s - {1'b0, WORDS};
        end
        return s[5:0];
    endfunction

    function automatic logic [29:0] seed_start(input logic [27:0] seed);
        logic [27:0] d;
        if (seed <= SEED_BASE) begin
            d = SEED_BASE - seed;
        end else begin
            d = seed - SEED_BASE;
        end
        return {2'b00, d};
    endfunction

endpackage

### rtl/subtractive_lagged_rng_unit.sv
// Top level of the subtractive lagged random generator (modulo one billion, 55-word table).
//
// Each input word asks for one raw value in 0..999999999, returned as a count of
// billionths of unity; scale by 1e-9 in software. A draw subtracts the word at the
// far index from the word at the near index modulo one billion and writes the
// difference back at the near index. With reseed set, or on the first request after
// reset, the table is first rebuilt from the seed register: one seed step, a 54-step
// fill in stride 21 and four warm-up passes over all 55 words. A microcoded sequencer
// steps through an eight-word control store and drives a datapath around a 55x30
// table memory with one write and two registered read ports. A plain draw passes through
// the accept, dispatch, read and write steps before the next possible acceptance; a
// rebuild adds the seed step, the fill steps and the warm-up steps, as every warm-up word
// needs a read step and a write step on the table memory. The input
// stalls whenever the sequencer is away from its idle step. The result sits in an
// output register, so the next word is accepted while a result still waits; a draw
// holds in its write step only if the previous result has not yet been taken. The
// seed port is always ready; write it only while the block is idle. The table has no
// reset: the rebuild that precedes the first draw fills every word.
module subtractive_lagged_rng_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_reseed,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output logic [29:0] o_random_value,
    input  logic        i_out_stall,
    input  logic        i_cfg_valid,
    input  logic [27:0] i_cfg_data,
    output logic        o_cfg_ready
);

    slrng_pkg::t_ctl   ctl;
    slrng_pkg::t_flags flags;

    // take a new word only at the idle step
    assign o_in_stall  = !ctl.accept;
    // seed writes go straight into the seed register, so never hold them off
    assign o_cfg_ready = 1'b1;

    slrng_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    slrng_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_flags        (flags),
        .i_in_valid     (i_in_valid),
        .i_reseed       (i_reseed),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .o_random_value (o_random_value),
        .i_out_stall    (i_out_stall)
    );

endmodule

### rtl/slrng_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module slrng_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slrng_pkg::t_flags i_flags,
    output slrng_pkg::t_ctl   o_ctl
);

    slrng_pkg::t_step  r_step;
    slrng_pkg::t_step  n_step;
    slrng_pkg::t_uword uw;
    logic              take;

    assign uw    = slrng_pkg::ucode(r_step);
    assign o_ctl = uw.ctl;

    always_comb begin
        unique case (uw.cond)
            slrng_pkg::C_NONE:      take = 1'b0;
            slrng_pkg::C_NO_INPUT:  take = !i_flags.in_valid;
            slrng_pkg::C_DRAW_ONLY: take = i_flags.draw_only;
            slrng_pkg::C_FILL_MORE: take = i_flags.fill_more;
            slrng_pkg::C_WARM_MORE: take = i_flags.warm_more;
            slrng_pkg::C_OUT_BUSY:  take = i_flags.out_busy;
            default:                take = 1'b0;
        endcase
        priority if (take) begin
            n_step = uw.target;
        end else if (uw.ret) begin
            n_step = slrng_pkg::STEP_IDLE;
        end else begin
            n_step = r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= slrng_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### rtl/slrng_dp.sv
// Datapath: lag table memory, fill and index registers, subtractor and output word.
module slrng_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slrng_pkg::t_ctl   i_ctl,
    output slrng_pkg::t_flags o_flags,
    input  logic              i_in_valid,
    input  logic              i_reseed,
    input  logic              i_cfg_valid,
    input  logic [27:0]       i_cfg_data,
    output logic              o_out_valid,
    output logic [29:0]       o_random_value,
    input  logic              i_out_stall
);

    logic [29:0] r_table [1:55];
    logic [29:0] r_rd_a;
    logic [29:0] r_rd_b;
    logic [29:0] r_cur;
    logic [29:0] r_prev;
    logic [29:0] r_out_value;
    logic [27:0] r_seed;
    logic [5:0]  r_slot;
    logic [5:0]  r_cnt;
    logic [5:0]  r_wi;
    logic [1:0]  r_pass;
    logic [5:0]  r_near;
    logic [5:0]  r_far;
    logic        r_init;
    logic        r_reseed;
    logic        r_out_valid;

    logic [5:0]  near_step;
    logic [5:0]  far_step;
    logic [5:0]  rd_addr_a;
    logic [5:0]  rd_addr_b;
    logic [5:0]  wr_addr;
    logic [29:0] wr_data;
    logic        wr_en;
    logic [29:0] diff;
    logic [29:0] start;
    logic        out_busy;
    logic        warm_last;
    logic        draw_fire;

    assign near_step = slrng_pkg::step_index(r_near);
    assign far_step  = slrng_pkg::step_index(r_far);
    assign diff      = slrng_pkg::mod_sub(r_rd_a, r_rd_b);
    assign start     = slrng_pkg::seed_start(r_seed);
    assign out_busy  = r_out_valid && i_out_stall;
    assign warm_last = (r_wi == slrng_pkg::WORDS) && (r_pass == slrng_pkg::LAST_PASS);
    assign draw_fire = i_ctl.draw_wr && !out_busy;

    assign o_flags.in_valid  = i_in_valid;
    assign o_flags.draw_only = r_init && !r_reseed;
    assign o_flags.fill_more = r_cnt != slrng_pkg::FILL_STEPS;
    assign o_flags.warm_more = !warm_last;
    assign o_flags.out_busy  = out_busy;

    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_value;

    // read both ports at the draw pair or at the warm-up pair
    always_comb begin
        if (i_ctl.draw_rd) begin
            rd_addr_a = near_step;
            rd_addr_b = far_step;
        end else begin
            rd_addr_a = r_wi;
            rd_addr_b = slrng_pkg::warm_other(r_wi);
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_near;
        wr_data = diff;
        priority if (i_ctl.seed_load) begin
            wr_addr = slrng_pkg::WORDS;
            wr_data = start;
        end else if (i_ctl.fill) begin
            wr_addr = r_slot;
            wr_data = r_prev;
        end else if (i_ctl.warm_wr) begin
            wr_addr = r_wi;
        end else if (draw_fire) begin
            wr_addr = r_near;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        if (i_ctl.draw_rd || i_ctl.warm_rd) begin
            r_rd_a <= r_table[rd_addr_a];
            r_rd_b <= r_table[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_in_valid) begin
            r_reseed <= i_reseed;
        end
        if (i_ctl.seed_load) begin
            r_cur  <= start;
            r_prev <= 30'd1;
            r_slot <= slrng_pkg::STRIDE;
            r_cnt  <= 6'd1;
            r_wi   <= 6'd1;
            r_pass <= 2'd0;
        end
        if (i_ctl.fill) begin
            r_cur  <= r_prev;
            r_prev <= slrng_pkg::mod_sub(r_cur, r_prev);
            r_slot <= slrng_pkg::next_slot(r_slot);
            r_cnt  <= r_cnt + 6'd1;
        end
        if (i_ctl.warm_wr) begin
            r_wi <= slrng_pkg::step_index(r_wi);
            if (r_wi == slrng_pkg::WORDS) begin
                r_pass <= r_pass + 2'd1;
            end
        end
        if (draw_fire) begin
            r_out_value <= diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_near      <= '0;
            r_far       <= slrng_pkg::FAR_START;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (i_ctl.warm_wr && warm_last) begin
                r_near <= '0;
                r_far  <= slrng_pkg::FAR_START;
                r_init <= 1'b1;
            end else if (i_ctl.draw_rd) begin
                r_near <= near_step;
                r_far  <= far_step;
            end
            if (draw_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/slrng_checker.sv
// Port-level checker for the subtractive lagged generator, bound to its top level.
`include "subtractive_lagged_rng_unit_assert.svh"

module slrng_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic [29:0] o_random_value,
    input logic        i_out_stall
);

    // drop any pending result on reset
    `SLRNG_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "result valid after reset")
    // every drawn value lies below one billion
    `SLRNG_ASSERT(a_value_range, o_out_valid |-> (o_random_value < slrng_pkg::MODULUS), "value out of range")
    // hold a stalled result
    `SLRNG_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_random_value)), "stalled result changed")
    // one word in flight: the input stalls right after an accept and no result appears yet
    `SLRNG_ASSERT(a_one_in_flight, (i_in_valid && !o_in_stall) |=> (o_in_stall && !$rose(o_out_valid)), "second word or early result")

endmodule

bind subtractive_lagged_rng_unit slrng_checker u_checker (.*);
